/* rtl/core/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list
// Store depth, count widths, operation and status codes, and the control
// word that the top level broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package sli_pkg;

    // number of list cells
    localparam int DEPTH = 16;
    // width of a count that can hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths of the channels
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int LCOUNT_W = 5;

    // operation codes on the input beat
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // status codes on the result beats
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // what every cell does at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_cmd_t;

    // broadcast control word
    typedef struct packed {
        cell_cmd_t               cmd;
        logic signed [VAL_W-1:0] val;
    } cell_ctl_t;

    // where a cell stands relative to the current fill
    typedef struct packed {
        logic valid;   // cell holds a live entry
        logic tail;    // cell holds the last live entry
    } cell_pos_t;

endpackage

/* rtl/core/sli_if.sv */
// ----------------------------------------------------------------------------
// sli_if: channel interfaces of the sorted list
// Operation channel (insert/remove requests) and list channel (streamed
// entries), each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface sli_op_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic signed [sli_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface sli_list_if;
    logic                                valid;
    logic                                ready;
    logic [sli_pkg::STAT_W-1:0]          status;
    logic [sli_pkg::LCOUNT_W-1:0]        list_count;
    logic signed [sli_pkg::VAL_W-1:0]    entry_value;
    logic                                last_entry;

    modport source (output valid, output status, output list_count,
                    output entry_value, output last_entry, input ready);
    modport sink   (input valid, input status, input list_count,
                    input entry_value, input last_entry, output ready);
endinterface

/* rtl/core/sli_cell.sv */
// ----------------------------------------------------------------------------
// sli_cell: one entry of the sorted list
// Holds one value and, on command, keeps it, takes the new value, takes a
// neighbor's value (shift on insert/remove) or rotates toward the head.
// ----------------------------------------------------------------------------
module sli_cell (
    input  logic                                clk,
    input  sli_pkg::cell_ctl_t                  ctl,
    input  sli_pkg::cell_pos_t                  pos,
    input  logic                                prev_ge,
    input  logic signed [sli_pkg::VAL_W-1:0]    prev_entry,
    input  logic signed [sli_pkg::VAL_W-1:0]    next_entry,
    input  logic signed [sli_pkg::VAL_W-1:0]    head_entry,
    output logic signed [sli_pkg::VAL_W-1:0]    entry,
    output logic                                ge,
    output logic                                hit
);

    logic signed [sli_pkg::VAL_W-1:0] entry_reg;
    logic signed [sli_pkg::VAL_W-1:0] entry_next;

    // value at or above this entry (empty cells count as below anything)
    assign ge    = !pos.valid || (ctl.val >= entry_reg);
    // first cell of the "at or below" run, and it holds the value itself
    assign hit   = pos.valid && ge && !prev_ge && (entry_reg == ctl.val);
    assign entry = entry_reg;

    // next entry
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.cmd)
            sli_pkg::CELL_INSERT:
            begin
                if (prev_ge)
                    entry_next = prev_entry;
                else if (ge)
                    entry_next = ctl.val;
            end
            sli_pkg::CELL_REMOVE:
            begin
                if (ge)
                    entry_next = next_entry;
            end
            sli_pkg::CELL_ROTATE:
            begin
                if (pos.valid)
                    entry_next = pos.tail ? head_entry : next_entry;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/sorted_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: descending sorted multiset of signed words
// Row of DEPTH cells holding the list, largest value in cell 0.
// ----------------------------------------------------------------------------
// Use:
//   op   : one beat per operation, func 0 inserts value, func 1 removes the
//          first entry equal to value. Taken only while no run is in flight.
//   list : after every operation the whole list, largest first, one beat per
//          entry, same status and list_count on every beat, last_entry on
//          the final one. An empty list gives a single beat with count 0.
// Timing:
//   The operation is applied in the cycle it is taken (parallel compare in
//   every cell, neighbor shift). The first list beat is valid the next
//   cycle. Each list beat rotates the cell row by one toward cell 0, so a
//   run of N entries leaves the list in place.
// Reset:
//   rst_n clears the fill count and the sequencer; cell contents are not
//   reset and only live cells are ever streamed.
// Stall:
//   With list.ready low the current beat holds and the row does not move.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove (
    input  logic          clk,
    input  logic          rst_n,
    sli_op_if.sink        op,
    sli_list_if.source    list
);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t                          state_reg;
    logic [sli_pkg::CNT_W-1:0]       count_reg;
    logic [sli_pkg::CNT_W-1:0]       count_next;
    logic [sli_pkg::CNT_W-1:0]       beat_reg;
    sli_pkg::status_t                status_reg;
    sli_pkg::status_t                status_next;

    sli_pkg::cell_ctl_t              ctl;
    sli_pkg::cell_pos_t              pos   [sli_pkg::DEPTH];
    logic signed [sli_pkg::VAL_W-1:0] ent  [sli_pkg::DEPTH];
    logic signed [sli_pkg::VAL_W-1:0] prv  [sli_pkg::DEPTH];
    logic signed [sli_pkg::VAL_W-1:0] nxt  [sli_pkg::DEPTH];
    logic                            ge    [sli_pkg::DEPTH];
    logic                            pge   [sli_pkg::DEPTH];
    logic [sli_pkg::DEPTH-1:0]       hits;

    logic op_fire;
    logic list_fire;
    logic is_full;
    logic is_empty;
    logic found;
    logic last_beat;

    assign op_fire   = op.valid && op.ready;
    assign list_fire = list.valid && list.ready;
    assign is_full   = (count_reg == sli_pkg::CNT_W'(sli_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);
    assign found     = |hits;
    assign last_beat = is_empty || ((beat_reg + 1'b1) == count_reg);

    // cell row with neighbor links
    genvar gi;
    generate
        for (gi = 0; gi < sli_pkg::DEPTH; gi++)
        begin : g_cell
            assign pos[gi].valid = (sli_pkg::CNT_W'(gi) < count_reg);
            assign pos[gi].tail  = (sli_pkg::CNT_W'(gi + 1) == count_reg);

            if (gi == 0)
            begin : g_head
                assign pge[gi] = 1'b0;
                assign prv[gi] = ctl.val;
            end
            else
            begin : g_body
                assign pge[gi] = ge[gi-1];
                assign prv[gi] = ent[gi-1];
            end

            if (gi == sli_pkg::DEPTH - 1)
            begin : g_end
                assign nxt[gi] = '0;
            end
            else
            begin : g_mid
                assign nxt[gi] = ent[gi+1];
            end

            sli_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (pos[gi]),
                .prev_ge    (pge[gi]),
                .prev_entry (prv[gi]),
                .next_entry (nxt[gi]),
                .head_entry (ent[0]),
                .entry      (ent[gi]),
                .ge         (ge[gi]),
                .hit        (hits[gi])
            );
        end
    endgenerate

    // command to the row, status and new fill count
    always_comb
    begin
        ctl.val     = op.value;
        ctl.cmd     = sli_pkg::CELL_HOLD;
        count_next  = count_reg;
        status_next = status_reg;
        if (op_fire)
        begin
            if (op.func == sli_pkg::FUNC_INSERT)
            begin
                if (is_full)
                    status_next = sli_pkg::STAT_FULL;
                else
                begin
                    status_next = sli_pkg::STAT_OK;
                    ctl.cmd     = sli_pkg::CELL_INSERT;
                    count_next  = count_reg + 1'b1;
                end
            end
            else if (is_empty)
                status_next = sli_pkg::STAT_EMPTY;
            else if (!found)
                status_next = sli_pkg::STAT_NOT_FOUND;
            else
            begin
                status_next = sli_pkg::STAT_OK;
                ctl.cmd     = sli_pkg::CELL_REMOVE;
                count_next  = count_reg - 1'b1;
            end
        end
        else if (list_fire && !is_empty)
            ctl.cmd = sli_pkg::CELL_ROTATE;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            beat_reg   <= '0;
            status_reg <= sli_pkg::STAT_OK;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (op_fire)
                    begin
                        state_reg <= ST_STREAM;
                        beat_reg  <= '0;
                    end
                end
                ST_STREAM:
                begin
                    if (list_fire)
                    begin
                        beat_reg <= beat_reg + 1'b1;
                        if (last_beat)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // channel outputs
    assign op.ready         = (state_reg == ST_IDLE);
    assign list.valid       = (state_reg == ST_STREAM);
    assign list.status      = status_reg;
    assign list.list_count  = sli_pkg::LCOUNT_W'(count_reg);
    assign list.entry_value = is_empty ? '0 : ent[0];
    assign list.last_entry  = last_beat;

    // an accepted operation always opens a run
    a_op_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        op_fire |=> list.valid)
        else $error("operation did not start a list run");

    // fill never passes the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sli_pkg::CNT_W'(sli_pkg::DEPTH))
        else $error("fill count beyond store depth");

    // fill count and status stay put for the whole run
    a_run_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (list.valid && !(list_fire && last_beat))
        |=> ($stable(count_reg) && $stable(status_reg)))
        else $error("count or status changed inside a run");

    // closing beat returns to idle
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (list_fire && last_beat) |=> (op.ready && !list.valid))
        else $error("run did not end after last beat");

endmodule
